[src/bps_pkg.sv]
`timescale 1ns / 1ps

package bps_pkg;

   localparam int COORD_W    = 32;
   localparam int T_W        = 16;
   localparam int STRIDE_W   = 4;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int WORD_W     = 3 * COORD_W;

   localparam int MAX_STRIDE_DEF = 8;
   localparam int T_STEP_MIN     = 2185;

   localparam logic       ORDER_RST  = 1'b0;
   localparam logic [3:0] STRIDE_RST = 4'd2;
   localparam logic [15:0] T_STEP_RST = 16'd3277;

   // shared multiplier operand and product widths
   localparam int MUL_A_W = 40;
   localparam int MUL_B_W = 24;
   localparam int PROD_W  = 64;

   // floor division by three: 2^18 = 3 * DIV3_HI + 1, and the reciprocal
   // DIV3_RECIP = (2^20 + 2) / 3 is exact for operands below 2^19
   localparam int DIV3_HI    = 87381;
   localparam int DIV3_RECIP = 349526;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CURVE_ORDER  = 2'd0,
      CSR_POINT_STRIDE = 2'd1,
      CSR_T_STEP       = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic acc_load;
      logic acc_add;
   } mac_ctl_type;

endpackage

[src/bps_mac.sv]
`timescale 1ns / 1ps

module bps_mac (
   input  logic                                  clock,
   input  logic signed [bps_pkg::MUL_A_W-1:0]   mul_a,
   input  logic signed [bps_pkg::MUL_B_W-1:0]   mul_b,
   input  bps_pkg::mac_ctl_type                  ctl,
   output logic signed [bps_pkg::PROD_W-1:0]    prod_ff,
   output logic signed [bps_pkg::PROD_W-1:0]    acc_ff
);

   logic signed [bps_pkg::PROD_W-1:0] prod_in;
   logic signed [bps_pkg::PROD_W-1:0] acc_in;

   always_comb begin
      prod_in = mul_a * mul_b;
      acc_in  = acc_ff;
      if (ctl.acc_load) begin
         acc_in = prod_ff;
      end else if (ctl.acc_add) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule

[src/bezier_path_smoother.sv]
`timescale 1ns / 1ps
// Channel | Direction | Signals                         | Word
// req     | in        | req_tvalid/tready/tdata/tlast   | one raw path point
// rsp     | out       | rsp_tvalid/tready/tdata/tuser/tlast | one output point
// csr     | in        | csr_valid/ready/index/wdata     | one register write
//
// One point is taken at a time; req_tready is high only between points. Reset is
// synchronous and returns to the start of a path with default regs.
// A curve sample runs weight steps, then axis steps for x, y and z in turn, then a
// hand-off, all on the one shared multiplier; a point also passes control states
// for its queued steps, to close, and idle. A result waits in a one-word hold
// register until the next result or the end of the point decides its tlast; a
// stalled rsp side stalls it.

module bezier_path_smoother #(
   parameter int MAX_STRIDE = bps_pkg::MAX_STRIDE_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bps_pkg::WORD_W-1:0]      req_tdata,  // pos_x, pos_y, pos_z
   input  logic                            req_tlast,  // final_point
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bps_pkg::WORD_W-1:0]      rsp_tdata,  // out_x, out_y, out_z
   output logic [1:0]                      rsp_tuser,  // from_raw, path_end
   output logic                            rsp_tlast,  // run_end
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [bps_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [bps_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int PH_W = (MAX_STRIDE > 1) ? $clog2(MAX_STRIDE) : 1;
   localparam int ST_W = $clog2(MAX_STRIDE + 1);
   localparam int CW   = bps_pkg::COORD_W;

   typedef enum logic [2:0] {
      S_IDLE, S_NEXT, S_FEED, S_WGT, S_AXIS, S_PUSH, S_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      OP_NONE, OP_FEED, OP_EMIT_CUR, OP_EMIT_EARLY
   } op_type;

   // control
   state_type        state_ff, state_in;
   logic             order_ff, order_in;
   logic [3:0]       stride_ff, stride_in;
   logic [15:0]      tstep_ff, tstep_in;
   logic [2:0]       fill_ff, fill_in;
   logic [PH_W-1:0]  phase_ff, phase_in;
   logic [1:0]       rawcnt_ff, rawcnt_in;
   op_type           op_ff [3];
   op_type           op_in [3];
   logic             pend_valid_ff, pend_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       seq_ff, seq_in;
   logic [1:0]       axis_ff, axis_in;

   // payload
   logic             cubic_ff, cubic_in;
   logic             final_ff, final_in;
   logic             ret_smp_ff, ret_smp_in;
   logic signed [CW-1:0] cur_ff [3];
   logic signed [CW-1:0] cur_in [3];
   logic signed [CW-1:0] early_ff [3];
   logic signed [CW-1:0] early_in [3];
   logic signed [CW-1:0] win_ff [3][4];
   logic signed [CW-1:0] win_in [3][4];
   logic signed [CW-1:0] res_ff [3];
   logic signed [CW-1:0] res_in [3];
   logic             res_raw_ff, res_raw_in;
   logic signed [CW-1:0] pend_ff [3];
   logic signed [CW-1:0] pend_in [3];
   logic             pend_raw_ff, pend_raw_in;
   logic signed [CW-1:0] rsp_ff [3];
   logic signed [CW-1:0] rsp_in [3];
   logic             rsp_raw_ff, rsp_raw_in;
   logic             rsp_last_ff, rsp_last_in;
   logic             rsp_path_ff, rsp_path_in;
   logic [15:0]      t_ff, t_in;
   logic [31:0]      tt_ff, tt_in;
   logic [32:0]      uu_ff, uu_in;
   logic signed [17:0] w1_ff, w1_in, w2_ff, w2_in, w3_ff, w3_in;
   logic signed [21:0] y_ff, y_in;
   logic signed [39:0] q1_ff, q1_in;

   // shared unit
   logic signed [bps_pkg::MUL_A_W-1:0] mul_a;
   logic signed [bps_pkg::MUL_B_W-1:0] mul_b;
   bps_pkg::mac_ctl_type               mac_ctl;
   logic signed [bps_pkg::PROD_W-1:0]  prod;
   logic signed [bps_pkg::PROD_W-1:0]  acc;

   bps_mac u_mac (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .ctl     (mac_ctl),
      .prod_ff (prod),
      .acc_ff  (acc)
   );

   function automatic logic signed [CW-1:0] sat_coord(input logic signed [63:0] v);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (CW - 1)) - 64'sd1;
      lo = -(64'sd1 <<< (CW - 1));
      if (v > hi) begin
         sat_coord = CW'(hi);
      end else if (v < lo) begin
         sat_coord = CW'(lo);
      end else begin
         sat_coord = CW'(v);
      end
   endfunction

   // derived values
   logic [ST_W-1:0]    stride_eff;
   logic [ST_W-1:0]    phase_inc;
   logic [15:0]        step_eff;
   logic [16:0]        u_val;
   logic [16:0]        t_next;
   logic signed [17:0] w0;
   logic signed [CW-1:0] cw [4];
   logic signed [35:0] ce [4];
   logic signed [35:0] coef [4];
   logic signed [35:0] coef_sel;
   logic signed [17:0] w_sel;
   logic signed [63:0] xs;
   logic signed [63:0] xh;
   logic signed [63:0] xl;
   logic [1:0]         rc_next;
   logic               first;
   logic               slot_free;
   logic [2:0]         fill_new;
   logic               do_smp;

   always_comb begin
      if (stride_ff == 4'd0) begin
         stride_eff = ST_W'(1);
      end else if (32'(stride_ff) > 32'(MAX_STRIDE)) begin
         stride_eff = ST_W'(MAX_STRIDE);
      end else begin
         stride_eff = ST_W'(stride_ff);
      end
      phase_inc = ST_W'(phase_ff) + ST_W'(1);
      step_eff  = (tstep_ff < 16'(bps_pkg::T_STEP_MIN)) ?
                  16'(bps_pkg::T_STEP_MIN) : tstep_ff;
      u_val     = 17'd65536 - {1'b0, t_ff};
      t_next    = {1'b0, t_ff} + {1'b0, step_eff};
      w0        = 18'sd65536 - w1_ff - w2_ff - w3_ff;

      case (axis_ff)
         2'd0:    cw = win_ff[0];
         2'd1:    cw = win_ff[1];
         default: cw = win_ff[2];
      endcase
      for (int i = 0; i < 4; i++) begin
         ce[i] = 36'(cw[i]);
      end
      // control points held exactly: times 6 cubic, times 2 quadratic
      if (cubic_ff) begin
         coef[0] = ce[0] + (ce[1] <<< 2) + ce[2];
         coef[1] = (ce[1] <<< 2) + (ce[2] <<< 1);
         coef[2] = (ce[1] <<< 1) + (ce[2] <<< 2);
         coef[3] = ce[1] + (ce[2] <<< 2) + ce[3];
      end else begin
         coef[0] = ce[1] + ce[2];
         coef[1] = ce[2] <<< 1;
         coef[2] = ce[2] + ce[3];
         coef[3] = '0;
      end
      coef_sel = coef[seq_ff[1:0]];
      case (seq_ff[1:0])
         2'd0:    w_sel = w0;
         2'd1:    w_sel = w1_ff;
         2'd2:    w_sel = w2_ff;
         default: w_sel = w3_ff;
      endcase

      xs = (acc + 64'sd196608) >>> 17;
      xh = xs >>> 18;
      xl = $signed({46'd0, xs[17:0]});
   end

   assign first     = (rawcnt_ff == 2'd0);
   assign rc_next   = (rawcnt_ff == 2'd3) ? 2'd3 : rawcnt_ff + 2'd1;
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign fill_new  = (fill_ff == 3'd4) ? 3'd4 : fill_ff + 3'd1;
   assign do_smp    = (rawcnt_ff == 2'd3) && (fill_new >= (cubic_ff ? 3'd4 : 3'd3));

   always_comb begin
      state_in      = state_ff;
      order_in      = order_ff;
      stride_in     = stride_ff;
      tstep_in      = tstep_ff;
      fill_in       = fill_ff;
      phase_in      = phase_ff;
      rawcnt_in     = rawcnt_ff;
      op_in         = op_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      seq_in        = seq_ff;
      axis_in       = axis_ff;
      cubic_in      = cubic_ff;
      final_in      = final_ff;
      ret_smp_in    = ret_smp_ff;
      cur_in        = cur_ff;
      early_in      = early_ff;
      win_in        = win_ff;
      res_in        = res_ff;
      res_raw_in    = res_raw_ff;
      pend_in       = pend_ff;
      pend_raw_in   = pend_raw_ff;
      rsp_in        = rsp_ff;
      rsp_raw_in    = rsp_raw_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_path_in   = rsp_path_ff;
      t_in          = t_ff;
      tt_in         = tt_ff;
      uu_in         = uu_ff;
      w1_in         = w1_ff;
      w2_in         = w2_ff;
      w3_in         = w3_ff;
      y_in          = y_ff;
      q1_in         = q1_ff;
      mul_a         = '0;
      mul_b         = '0;
      mac_ctl       = '0;

      // the user must send config writes only while idle; the block does not enforce it
      if (csr_valid) begin
         case (csr_index)
            bps_pkg::CSR_CURVE_ORDER:  order_in  = csr_wdata[0];
            bps_pkg::CSR_POINT_STRIDE: stride_in = csr_wdata[3:0];
            bps_pkg::CSR_T_STEP:       tstep_in  = csr_wdata;
            default: ;
         endcase
      end

      // drop the output word once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cur_in[0] = req_tdata[CW-1:0];
               cur_in[1] = req_tdata[2*CW-1:CW];
               cur_in[2] = req_tdata[3*CW-1:2*CW];
               final_in  = req_tlast;
               cubic_in  = order_ff;
               rawcnt_in = rc_next;
               if (first) begin
                  early_in[0] = req_tdata[CW-1:0];
                  early_in[1] = req_tdata[2*CW-1:CW];
                  early_in[2] = req_tdata[3*CW-1:2*CW];
                  fill_in     = '0;
                  phase_in    = '0;
               end
               if (!order_ff) begin
                  op_in[0] = first ? OP_EMIT_CUR : OP_FEED;
                  op_in[1] = first ? OP_FEED : (req_tlast ? OP_EMIT_CUR : OP_NONE);
                  op_in[2] = OP_NONE;
               end else if (first) begin
                  op_in[0] = OP_FEED;
                  op_in[1] = OP_FEED;
                  op_in[2] = req_tlast ? OP_EMIT_CUR : OP_NONE;
               end else if (req_tlast) begin
                  op_in[0] = OP_FEED;
                  op_in[1] = (rc_next == 2'd3) ? OP_FEED : OP_EMIT_EARLY;
                  op_in[2] = OP_EMIT_CUR;
               end else begin
                  op_in[0] = OP_FEED;
                  op_in[1] = OP_NONE;
                  op_in[2] = OP_NONE;
               end
               state_in = S_NEXT;
            end
         end

         S_NEXT: begin
            op_in[0] = op_ff[1];
            op_in[1] = op_ff[2];
            op_in[2] = OP_NONE;
            ret_smp_in = 1'b0;
            res_raw_in = 1'b1;
            case (op_ff[0])
               OP_FEED: begin
                  state_in = S_FEED;
               end
               OP_EMIT_CUR: begin
                  res_in   = cur_ff;
                  state_in = S_PUSH;
               end
               OP_EMIT_EARLY: begin
                  res_in   = early_ff;
                  state_in = S_PUSH;
               end
               default: begin
                  state_in = S_FLUSH;
               end
            endcase
         end

         S_FEED: begin
            state_in = S_NEXT;
            if (phase_ff == '0) begin
               for (int a = 0; a < 3; a++) begin
                  win_in[a][0] = win_ff[a][1];
                  win_in[a][1] = win_ff[a][2];
                  win_in[a][2] = win_ff[a][3];
                  win_in[a][3] = cur_ff[a];
               end
               fill_in = fill_new;
               if (do_smp) begin
                  t_in     = '0;
                  seq_in   = '0;
                  state_in = S_WGT;
               end
            end
            phase_in = (phase_inc >= stride_eff) ? '0 : PH_W'(phase_inc);
         end

         S_WGT: begin
            seq_in = seq_ff + 3'd1;
            if (cubic_ff) begin
               case (seq_ff)
                  3'd0: begin
                     mul_a = bps_pkg::MUL_A_W'({1'b0, t_ff});
                     mul_b = bps_pkg::MUL_B_W'({1'b0, t_ff});
                  end
                  3'd1: begin
                     tt_in = prod[31:0];
                     mul_a = bps_pkg::MUL_A_W'(u_val);
                     mul_b = bps_pkg::MUL_B_W'(u_val);
                  end
                  3'd2: begin
                     uu_in = prod[32:0];
                     mul_a = bps_pkg::MUL_A_W'(tt_ff);
                     mul_b = bps_pkg::MUL_B_W'({1'b0, t_ff});
                  end
                  3'd3: begin
                     w3_in = 18'((prod + 64'sd2147483648) >>> 32);
                     mul_a = bps_pkg::MUL_A_W'(tt_ff);
                     mul_b = bps_pkg::MUL_B_W'(u_val);
                  end
                  3'd4: begin
                     w2_in = 18'((prod + (prod <<< 1) + 64'sd2147483648) >>> 32);
                     mul_a = bps_pkg::MUL_A_W'(uu_ff);
                     mul_b = bps_pkg::MUL_B_W'({1'b0, t_ff});
                  end
                  default: begin
                     w1_in    = 18'((prod + (prod <<< 1) + 64'sd2147483648) >>> 32);
                     seq_in   = '0;
                     axis_in  = '0;
                     state_in = S_AXIS;
                  end
               endcase
            end else begin
               case (seq_ff)
                  3'd0: begin
                     mul_a = bps_pkg::MUL_A_W'({1'b0, t_ff});
                     mul_b = bps_pkg::MUL_B_W'({1'b0, t_ff});
                  end
                  3'd1: begin
                     w2_in = 18'((prod + 64'sd32768) >>> 16);
                     w3_in = '0;
                     mul_a = bps_pkg::MUL_A_W'(u_val);
                     mul_b = bps_pkg::MUL_B_W'({1'b0, t_ff});
                  end
                  default: begin
                     w1_in    = 18'(((prod <<< 1) + 64'sd32768) >>> 16);
                     seq_in   = '0;
                     axis_in  = '0;
                     state_in = S_AXIS;
                  end
               endcase
            end
         end

         S_AXIS: begin
            seq_in = seq_ff + 3'd1;
            // issue control point times weight, then fold into the sum
            if (seq_ff <= (cubic_ff ? 3'd3 : 3'd2)) begin
               mul_a = bps_pkg::MUL_A_W'(coef_sel);
               mul_b = bps_pkg::MUL_B_W'(w_sel);
            end
            if (seq_ff == 3'd1) begin
               mac_ctl.acc_load = 1'b1;
            end else if (seq_ff >= 3'd2 && seq_ff <= (cubic_ff ? 3'd4 : 3'd3)) begin
               mac_ctl.acc_add = 1'b1;
            end
            if (!cubic_ff && seq_ff == 3'd4) begin
               res_in[axis_ff] = sat_coord((acc + 64'sd65536) >>> 17);
            end
            if (cubic_ff) begin
               case (seq_ff)
                  3'd5: begin
                     y_in  = 22'(xh + xl);
                     mul_a = bps_pkg::MUL_A_W'(xh);
                     mul_b = bps_pkg::MUL_B_W'(bps_pkg::DIV3_HI);
                  end
                  3'd6: begin
                     q1_in = prod[39:0];
                     mul_a = bps_pkg::MUL_A_W'(y_ff) + 40'sd196608;
                     mul_b = bps_pkg::MUL_B_W'(bps_pkg::DIV3_RECIP);
                  end
                  3'd7: begin
                     res_in[axis_ff] = sat_coord(64'(q1_ff) + (prod >>> 20) - 64'sd65536);
                  end
                  default: ;
               endcase
            end
            if (seq_ff == (cubic_ff ? 3'd7 : 3'd4)) begin
               seq_in = '0;
               if (axis_ff == 2'd2) begin
                  res_raw_in = 1'b0;
                  ret_smp_in = 1'b1;
                  state_in   = S_PUSH;
               end else begin
                  axis_in = axis_ff + 2'd1;
               end
            end
         end

         S_PUSH: begin
            if (!pend_valid_ff || slot_free) begin
               if (pend_valid_ff) begin
                  rsp_in       = pend_ff;
                  rsp_raw_in   = pend_raw_ff;
                  rsp_last_in  = 1'b0;
                  rsp_path_in  = 1'b0;
                  rsp_valid_in = 1'b1;
               end
               pend_in       = res_ff;
               pend_raw_in   = res_raw_ff;
               pend_valid_in = 1'b1;
               state_in      = S_NEXT;
               if (ret_smp_ff && !t_next[16]) begin
                  t_in     = t_next[15:0];
                  seq_in   = '0;
                  state_in = S_WGT;
               end
            end
         end

         S_FLUSH: begin
            if (!pend_valid_ff || slot_free) begin
               if (pend_valid_ff) begin
                  rsp_in        = pend_ff;
                  rsp_raw_in    = pend_raw_ff;
                  rsp_last_in   = 1'b1;
                  rsp_path_in   = final_ff;
                  rsp_valid_in  = 1'b1;
                  pend_valid_in = 1'b0;
               end
               if (final_ff) begin
                  rawcnt_in = '0;
                  fill_in   = '0;
                  phase_in  = '0;
               end
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      cubic_ff    <= cubic_in;
      final_ff    <= final_in;
      ret_smp_ff  <= ret_smp_in;
      cur_ff      <= cur_in;
      early_ff    <= early_in;
      win_ff      <= win_in;
      res_ff      <= res_in;
      res_raw_ff  <= res_raw_in;
      pend_ff     <= pend_in;
      pend_raw_ff <= pend_raw_in;
      rsp_ff      <= rsp_in;
      rsp_raw_ff  <= rsp_raw_in;
      rsp_last_ff <= rsp_last_in;
      rsp_path_ff <= rsp_path_in;
      t_ff        <= t_in;
      tt_ff       <= tt_in;
      uu_ff       <= uu_in;
      w1_ff       <= w1_in;
      w2_ff       <= w2_in;
      w3_ff       <= w3_in;
      y_ff        <= y_in;
      q1_ff       <= q1_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         order_ff      <= bps_pkg::ORDER_RST;
         stride_ff     <= bps_pkg::STRIDE_RST;
         tstep_ff      <= bps_pkg::T_STEP_RST;
         fill_ff       <= '0;
         phase_ff      <= '0;
         rawcnt_ff     <= '0;
         op_ff         <= '{OP_NONE, OP_NONE, OP_NONE};
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         seq_ff        <= '0;
         axis_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         order_ff      <= order_in;
         stride_ff     <= stride_in;
         tstep_ff      <= tstep_in;
         fill_ff       <= fill_in;
         phase_ff      <= phase_in;
         rawcnt_ff     <= rawcnt_in;
         op_ff         <= op_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         seq_ff        <= seq_in;
         axis_ff       <= axis_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff[2], rsp_ff[1], rsp_ff[0]};
   assign rsp_tuser  = {rsp_path_ff, rsp_raw_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

[src/bps_checker.sv]
`timescale 1ns / 1ps

module bps_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [bps_pkg::WORD_W-1:0]      req_tdata,
   input logic                            req_tlast,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bps_pkg::WORD_W-1:0]      rsp_tdata,
   input logic [1:0]                      rsp_tuser,
   input logic                            rsp_tlast,
   input logic                            csr_valid,
   input logic                            csr_ready,
   input logic [bps_pkg::CSR_IDX_W-1:0]   csr_index,
   input logic [bps_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   // hold a stalled output word
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // one point at a time: busy right after a point is taken
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("req taken back to back");

   // end of path closes the run and is always a raw point
   a_path_end_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast && rsp_tuser[0])
      else $error("path end without run end or on a curve sample");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("output not empty after reset");

endmodule

bind bezier_path_smoother bps_checker u_bps_checker (.*);

[sim/testbench.sv]
`timescale 1ns / 1ps

module testbench;

   localparam int  CLK_HALF    = 4;
   localparam int  RESET_CYC   = 6;
   localparam int  SETTLE_CYC  = 60;
   localparam int  TAIL_CYC    = 100;
   localparam int  CYCLE_LIMIT = 3000000;
   localparam int  RAND_ITEMS  = 260;
   localparam int  PHASE_ITEMS = 35;
   localparam int  IDLE_MAX    = 6;

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [bps_pkg::WORD_W-1:0] req_tdata;   // pos_x, pos_y, pos_z
   logic              req_tlast;   // final_point
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [bps_pkg::WORD_W-1:0] rsp_tdata;   // out_x, out_y, out_z
   logic [1:0]        rsp_tuser;   // from_raw, path_end
   logic              rsp_tlast;   // run_end
   logic              csr_valid;
   logic              csr_ready;
   logic [bps_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [bps_pkg::CSR_DATA_W-1:0] csr_wdata;

   bezier_path_smoother u_dut (.*);

   // one output word as the predictor sees it
   typedef struct {
      logic [31:0] x, y, z;
      bit          raw, run_end, path_end;
   } point_word_type;

   // directed stimulus row: either a point or a register write
   typedef struct {
      bit                     is_csr;
      bps_pkg::csr_index_type idx;
      logic [15:0]            val;
      logic [31:0]            x, y, z;
      bit                     fin;
      bit                     typed;   // expectation is written out in the row
   } stim_row_type;

   point_word_type expected_points[$];
   stim_row_type   stim_table[$];
   int          errors = 0;
   int          cycles = 0;
   bit          quiet  = 0;

   // predictor copy of the block's state and registers
   longint      win_x[4], win_y[4], win_z[4];
   int          win_fill, stride_pos, path_points;
   longint      first_x, first_y, first_z;
   bit          reg_order;
   logic [3:0]  reg_stride;
   logic [15:0] reg_step;

   initial begin
      clock = 0;
      forever #CLK_HALF clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic longint floor_quot(longint v, longint d);
      longint q;
      q = v / d;
      if ((v % d) != 0 && v < 0) q = q - 1;
      return q;
   endfunction

   function automatic logic [31:0] clip32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return v[31:0];
   endfunction

   function automatic longint quad_coord(longint a1, longint a2, longint a3,
                                         longint w0, longint w1, longint w2);
      return floor_quot(w0 * (a1 + a2) + w1 * (2 * a2) + w2 * (a2 + a3) + 65536,
                        131072);
   endfunction

   function automatic longint cubic_coord(longint a0, longint a1, longint a2,
                                          longint a3, longint k0, longint k1,
                                          longint k2, longint k3);
      longint acc;
      acc = k0 * (a0 + 4 * a1 + a2) + k1 * (4 * a1 + 2 * a2)
          + k2 * (2 * a1 + 4 * a2) + k3 * (a1 + 4 * a2 + a3);
      return floor_quot(acc + 3 * 65536, 6 * 65536);
   endfunction

   task automatic add_point(longint x, longint y, longint z, bit raw);
      point_word_type p;
      p.x = clip32(x);
      p.y = clip32(y);
      p.z = clip32(z);
      p.raw = raw;
      p.run_end = 0;
      p.path_end = 0;
      expected_points = {expected_points, p};
   endtask

   // sample the window at t = 0, step, 2*step ... while t < 1
   task automatic sample_curve(bit cubic);
      longint unsigned t, u, stp, h;
      longint k0, k1, k2, k3;
      stp = (reg_step < bps_pkg::T_STEP_MIN) ? bps_pkg::T_STEP_MIN : reg_step;
      h = 64'd1 << 31;
      for (t = 0; t < 65536; t += stp) begin
         u = 65536 - t;
         if (!cubic) begin
            k2 = (t * t + 32768) >> 16;
            k1 = (2 * u * t + 32768) >> 16;
            k0 = 65536 - k1 - k2;
            add_point(quad_coord(win_x[1], win_x[2], win_x[3], k0, k1, k2),
                      quad_coord(win_y[1], win_y[2], win_y[3], k0, k1, k2),
                      quad_coord(win_z[1], win_z[2], win_z[3], k0, k1, k2), 0);
         end else begin
            k3 = (t * t * t + h) >> 32;
            k2 = (3 * u * t * t + h) >> 32;
            k1 = (3 * u * u * t + h) >> 32;
            k0 = 65536 - k1 - k2 - k3;
            add_point(cubic_coord(win_x[0], win_x[1], win_x[2], win_x[3], k0, k1, k2, k3),
                      cubic_coord(win_y[0], win_y[1], win_y[2], win_y[3], k0, k1, k2, k3),
                      cubic_coord(win_z[0], win_z[1], win_z[2], win_z[3], k0, k1, k2, k3),
                      0);
         end
      end
   endtask

   // shift a kept point into the window on stride phase zero
   task automatic take_point(longint x, longint y, longint z, int stride, bit cubic);
      if (stride_pos == 0) begin
         for (int k = 0; k < 3; k++) begin
            win_x[k] = win_x[k+1];
            win_y[k] = win_y[k+1];
            win_z[k] = win_z[k+1];
         end
         win_x[3] = x;
         win_y[3] = y;
         win_z[3] = z;
         if (win_fill < 4) win_fill++;
         if (path_points >= 3 && win_fill >= (cubic ? 4 : 3)) sample_curve(cubic);
      end
      stride_pos++;
      if (stride_pos >= stride) stride_pos = 0;
   endtask

   task automatic predict_smoothed(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                   bit fin);
      longint x, y, z;
      bit     first;
      int     stride, n0;
      x = longint'($signed(px));
      y = longint'($signed(py));
      z = longint'($signed(pz));
      first = (path_points == 0);
      stride = (reg_stride < 1) ? 1 :
               (reg_stride > bps_pkg::MAX_STRIDE_DEF) ? bps_pkg::MAX_STRIDE_DEF :
               int'(reg_stride);
      n0 = expected_points.size();
      if (first) begin
         first_x = x;
         first_y = y;
         first_z = z;
         win_fill = 0;
         stride_pos = 0;
      end
      if (path_points < 3) path_points++;
      if (!reg_order) begin
         if (first) add_point(x, y, z, 1);
         take_point(x, y, z, stride, 0);
         if (fin && !first) add_point(x, y, z, 1);
      end else begin
         take_point(x, y, z, stride, 1);
         if (first) take_point(x, y, z, stride, 1);
         if (fin) begin
            // pad the tail in cubic mode; short paths pass through
            if (path_points >= 3) take_point(x, y, z, stride, 1);
            else if (!first) add_point(first_x, first_y, first_z, 1);
            add_point(x, y, z, 1);
         end
      end
      if (expected_points.size() > n0) begin
         expected_points[expected_points.size()-1].run_end = 1;
         if (fin) expected_points[expected_points.size()-1].path_end = 1;
      end
      if (fin) begin
         path_points = 0;
         win_fill = 0;
         stride_pos = 0;
      end
   endtask

   // compare each output word with the oldest expectation
   always @(posedge clock) begin
      point_word_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_points.size() == 0) begin
            $display("%0t: unexpected word x=%h y=%h z=%h", $time,
                     rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64]);
            errors++;
         end else begin
            e = expected_points.pop_front();
            if (rsp_tdata !== {e.z, e.y, e.x} || rsp_tuser !== {e.path_end, e.raw}
                || rsp_tlast !== e.run_end) begin
               $display("%0t: mismatch exp x=%h y=%h z=%h raw=%b end=%b path=%b",
                        $time, e.x, e.y, e.z, e.raw, e.run_end, e.path_end);
               $display("%0t:          got x=%h y=%h z=%h raw=%b end=%b path=%b",
                        $time, rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64],
                        rsp_tuser[0], rsp_tlast, rsp_tuser[1]);
               errors++;
            end
         end
      end
   end

   // output side: hold tready low at random before each word, not in quiet phases
   initial begin
      int n;
      rsp_tready = 0;
      @(negedge clock);
      forever begin
         n = quiet ? 0 : $urandom_range(0, IDLE_MAX);
         repeat (n) begin
            rsp_tready = 0;
            @(negedge clock);
         end
         rsp_tready = 1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, bit fin,
                             bit typed);
      int n;
      point_word_type p;
      n = quiet ? 0 : $urandom_range(0, IDLE_MAX);
      repeat (n) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      req_tdata  = {z, y, x};
      req_tlast  = fin;
      req_tvalid = 1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_smoothed(x, y, z, fin);
      if (typed) begin
         // lone point: passed through once and closes the path
         p.x = x;
         p.y = y;
         p.z = z;
         p.raw = 1;
         p.run_end = 1;
         p.path_end = 1;
         expected_points[expected_points.size()-1] = p;
      end
      @(negedge clock);
      req_tvalid = 0;
   endtask

   // wait for the block to drain before touching a register
   task automatic drain();
      while (expected_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(bps_pkg::csr_index_type idx, logic [15:0] val);
      csr_index = idx;
      csr_wdata = val;
      csr_valid = 1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         bps_pkg::CSR_CURVE_ORDER:  reg_order  = val[0];
         bps_pkg::CSR_POINT_STRIDE: reg_stride = val[3:0];
         bps_pkg::CSR_T_STEP:       reg_step   = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 0;
   endtask

   function automatic void row_pt(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                  bit fin, bit typed = 0);
      stim_row_type r;
      r = '{0, bps_pkg::CSR_CURVE_ORDER, 16'd0, x, y, z, fin, typed};
      stim_table = {stim_table, r};
   endfunction

   function automatic void row_csr(bps_pkg::csr_index_type idx, logic [15:0] val);
      stim_row_type r;
      r = '{1, idx, val, 32'd0, 32'd0, 32'd0, 0, 0};
      stim_table = {stim_table, r};
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 3))
         0:       return $urandom;
         1:       return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
         default: return $urandom_range(0, 32'h01ffffff) - 32'h01000000;
      endcase
   endfunction

   function automatic logic [15:0] rand_step();
      case ($urandom_range(0, 7))
         0:       return 16'd0;
         1:       return 16'(bps_pkg::T_STEP_MIN);
         2:       return 16'd32768;
         3:       return 16'hffff;
         default: return 16'($urandom_range(bps_pkg::T_STEP_MIN, 20000));
      endcase
   endfunction

   function automatic logic [15:0] rand_stride();
      case ($urandom_range(0, 5))
         0:       return 16'd0;
         1:       return 16'd15;
         2:       return 16'd8;
         3:       return 16'd1;
         default: return 16'($urandom_range(1, 8));
      endcase
   endfunction

   initial begin
      int sent, len, phase_cnt;
      reset      = 1;
      req_tvalid = 0;
      req_tdata  = '0;
      req_tlast  = 0;
      csr_valid  = 0;
      csr_index  = bps_pkg::CSR_CURVE_ORDER;
      csr_wdata  = '0;
      reg_order  = bps_pkg::ORDER_RST;
      reg_stride = bps_pkg::STRIDE_RST;
      reg_step   = bps_pkg::T_STEP_RST;
      path_points = 0;
      win_fill   = 0;
      stride_pos = 0;
      for (int k = 0; k < 4; k++) begin
         win_x[k] = 0;
         win_y[k] = 0;
         win_z[k] = 0;
      end
      repeat (RESET_CYC) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // lone points at the coordinate extremes under reset settings
      row_pt(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1, 1);
      row_pt(32'h80000000, 32'h80000000, 32'h80000000, 1, 1);
      // quadratic path, default stride and step
      row_pt(32'h00000000, 32'h00010000, 32'hffff0000, 0);
      row_pt(32'h00050000, 32'h00020000, 32'h00030000, 0);
      row_pt(32'h000a0000, 32'hfff00000, 32'h00000000, 0);
      row_pt(32'h000f0000, 32'h00100000, 32'h00070000, 1);
      // stride one, half step, swinging between the extremes
      row_csr(bps_pkg::CSR_POINT_STRIDE, 16'd1);
      row_csr(bps_pkg::CSR_T_STEP, 16'd32768);
      row_pt(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0);
      row_pt(32'h80000000, 32'h7fffffff, 32'h80000000, 0);
      row_pt(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1);
      // cubic: two-point path passes through, then a short curve
      row_csr(bps_pkg::CSR_CURVE_ORDER, 16'd1);
      row_pt(32'h00010000, 32'h00020000, 32'h00030000, 0);
      row_pt(32'h00040000, 32'h00050000, 32'h00060000, 1);
      // smallest step and a stride below range
      row_csr(bps_pkg::CSR_T_STEP, 16'd0);
      row_csr(bps_pkg::CSR_POINT_STRIDE, 16'd0);
      row_pt(32'h00000000, 32'h00000000, 32'h00000000, 0);
      row_pt(32'h00100000, 32'hfff00000, 32'h00080000, 0);
      row_pt(32'h00200000, 32'h00100000, 32'hfff80000, 1);
      // largest step, stride above range, mode change inside a path
      row_csr(bps_pkg::CSR_T_STEP, 16'hffff);
      row_csr(bps_pkg::CSR_POINT_STRIDE, 16'd15);
      row_pt(32'h00030000, 32'h00010000, 32'h00020000, 0);
      row_pt(32'h00060000, 32'h00040000, 32'h00020000, 0);
      row_csr(bps_pkg::CSR_CURVE_ORDER, 16'd0);
      row_pt(32'h00090000, 32'h00070000, 32'h00020000, 0);
      row_pt(32'h000c0000, 32'h000a0000, 32'h00020000, 1);

      foreach (stim_table[i]) begin
         if (stim_table[i].is_csr) begin
            drain();
            write_reg(stim_table[i].idx, stim_table[i].val);
         end else begin
            send_point(stim_table[i].x, stim_table[i].y, stim_table[i].z,
                       stim_table[i].fin, stim_table[i].typed);
         end
      end

      // random paths; settings change between phases of whole paths
      sent = 0;
      phase_cnt = 0;
      while (sent < RAND_ITEMS) begin
         if (phase_cnt >= PHASE_ITEMS) begin
            drain();
            quiet = ($urandom_range(0, 3) == 0);
            write_reg(bps_pkg::CSR_CURVE_ORDER, 16'($urandom_range(0, 1)));
            write_reg(bps_pkg::CSR_POINT_STRIDE, rand_stride());
            write_reg(bps_pkg::CSR_T_STEP, rand_step());
            phase_cnt = 0;
         end
         len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 12);
         for (int k = 0; k < len; k++) begin
            send_point(rand_coord(), rand_coord(), rand_coord(), k == len - 1, 0);
            sent++;
            phase_cnt++;
         end
      end

      while (expected_points.size() != 0) @(posedge clock);
      repeat (TAIL_CYC) @(posedge clock);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[bezier_path_smoother.f]
src/bps_pkg.sv
src/bps_mac.sv
src/bezier_path_smoother.sv
src/bps_checker.sv
sim/testbench.sv
